// ===== design/cfrp_pkg.sv =====
// Shared constants, types and helpers for the cache fill run planner.
`default_nettype none

package cfrp_pkg;

    localparam int NUM_BLOCKS  = 65536;
    localparam int BLOCK_BYTES = 4096;
    localparam int MAX_RUNS    = 16;

    localparam int MAX_SPAN  = 32;
    localparam int OUT_LIMIT = 16;
    localparam int RUN_CAP   = (MAX_RUNS < OUT_LIMIT) ? MAX_RUNS : OUT_LIMIT;

    // Bitmap is stored as 32-bit rows; only blocks a 16-bit index can reach.
    localparam int ROW_BITS   = 32;
    localparam int ROW_SHIFT  = 5;
    localparam int MAP_BLOCKS = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
    localparam int MAP_ROWS   = (MAP_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

    // Remainder unit: 29-bit operands (offset plus length cannot carry further).
    localparam int MOD_W = 29;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_CACHE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_row;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_row;
        logic [ROW_BITS-1:0] wr_data;
    } map_req_t;

    typedef struct packed {
        logic done;
        logic rem0_nz;
        logic rem1_nz;
    } mod_stat_t;

    function automatic logic [ROW_W-1:0] row_of(input logic [15:0] blk);
        logic [15:0] r;
        r = blk >> ROW_SHIFT;
        return r[ROW_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/cache_fill_run_planner.sv =====
// Cache fill run planner top level: request sequencer, block window and result port.
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------------------
//  request   start / busy            kind, first_block, last_block, byte_offset,
//                                    byte_length
//  result    result_valid (strobe)   fetch_valid, run_first, run_blocks, range_error, last
//
// Clearing: after reset the bitmap is cleared one 32-bit row per cycle (MAP_ROWS rows,
//   2048 at 65536 blocks) with busy high.
// A read or cache request reads two rows, tests one block per cycle in the window,
//   writes one or two rows back, then finishes.
// A write request walks the same way; its partial-block tests are registered at accept,
//   and it adds the ST_WLAST state only when it fetches two blocks.
// Kind "other" and bad ranges answer in the next cycle and leave busy low.
// Results are one-cycle strobes; the receiver cannot hold them off.
`default_nettype none

module cache_fill_run_planner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] first_block,
    input  wire logic [15:0] last_block,
    input  wire logic [27:0] byte_offset,
    input  wire logic [17:0] byte_length,
    output logic             result_valid,
    output logic             fetch_valid,
    output logic [15:0]      run_first,
    output logic [5:0]       run_blocks,
    output logic             range_error,
    output logic             last
);
    import cfrp_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_RD1   = 9'b0_0000_0100,
        ST_LOAD  = 9'b0_0000_1000,
        ST_WALK  = 9'b0_0001_0000,
        ST_WB0   = 9'b0_0010_0000,
        ST_WB1   = 9'b0_0100_0000,
        ST_FIN   = 9'b0_1000_0000,
        ST_WLAST = 9'b1_0000_0000
    } state_t;

    state_t             state_reg,    state_next;
    logic [ROW_W-1:0]   clr_row_reg,  clr_row_next;
    logic [4:0]         count_reg,    count_next;
    logic [5:0]         open_len_reg, open_len_next;
    logic [15:0]        open_first_reg, open_first_next;
    logic [1:0]         kind_reg,     kind_next;
    logic [15:0]        blk_reg,      blk_next;
    logic [15:0]        first_reg,    first_next;
    logic [15:0]        last_reg,     last_next;
    logic [5:0]         pos_reg,      pos_next;
    logic [2*ROW_BITS-1:0] win_reg,   win_next;
    logic               f_orig_reg,   f_orig_next;
    logic               l_orig_reg,   l_orig_next;

    logic               res_valid_reg, res_valid_next;
    logic               res_fv_reg,   res_fv_next;
    logic [15:0]        res_first_reg, res_first_next;
    logic [5:0]         res_blocks_reg, res_blocks_next;
    logic               res_err_reg,  res_err_next;
    logic               res_last_reg, res_last_next;

    map_req_t            map_req;
    logic [ROW_BITS-1:0] map_rd_data;
    mod_stat_t           mod_stat;
    logic                mod_start;
    logic                accept;
    logic                bad_range;
    logic                two_rows;

    assign accept   = start && !busy;
    assign two_rows = (row_of(first_reg) != row_of(last_reg));

    // Span check on the raw request: reversed, longer than MAX_SPAN, or off the map.
    assign bad_range = (last_block < first_block)
                    || ((last_block - first_block) > 16'(MAX_SPAN - 1))
                    || (32'(last_block) >= 32'(NUM_BLOCKS));

    assign mod_start = accept && (kind != KIND_OTHER) && !bad_range;

    cfrp_map u_map (
        .clk     (clk),
        .req     (map_req),
        .rd_data (map_rd_data)
    );

    cfrp_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .op0   (MOD_W'(byte_offset)),
        .op1   (MOD_W'(byte_offset) + MOD_W'(byte_length)),
        .stat  (mod_stat)
    );

    always_comb
    begin
        logic       cur;
        logic       adj;
        logic [4:0] cnt_v;
        logic       get_first;
        logic       get_last;

        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        count_next      = count_reg;
        open_len_next   = open_len_reg;
        open_first_next = open_first_reg;
        kind_next       = kind_reg;
        blk_next        = blk_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        win_next        = win_reg;
        f_orig_next     = f_orig_reg;
        l_orig_next     = l_orig_reg;

        res_valid_next  = 1'b0;
        res_fv_next     = 1'b0;
        res_first_next  = '0;
        res_blocks_next = '0;
        res_err_next    = 1'b0;
        res_last_next   = 1'b1;

        map_req         = '0;

        cur       = win_reg[pos_reg];
        adj       = (open_len_reg != '0)
                 && ({1'b0, blk_reg} == ({1'b0, open_first_reg} + 17'(open_len_reg)));
        cnt_v     = count_reg;
        get_first = mod_stat.rem0_nz && !f_orig_reg;
        get_last  = mod_stat.rem1_nz && ((last_reg > first_reg) || !get_first)
                 && !l_orig_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_req.wr_en  = 1'b1;
                map_req.wr_row = clr_row_reg;
                clr_row_next   = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(MAP_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_OTHER)
                    begin
                        res_valid_next = 1'b1;
                    end
                    else if (bad_range)
                    begin
                        res_valid_next = 1'b1;
                        res_err_next   = 1'b1;
                    end
                    else
                    begin
                        kind_next       = kind;
                        blk_next        = first_block;
                        first_next      = first_block;
                        last_next       = last_block;
                        pos_next        = {1'b0, first_block[ROW_SHIFT-1:0]};
                        count_next      = '0;
                        open_len_next   = '0;
                        open_first_next = '0;
                        map_req.rd_en   = 1'b1;
                        map_req.rd_row  = row_of(first_block);
                        state_next      = ST_RD1;
                    end
                end
            end

            ST_RD1:
            begin
                win_next[ROW_BITS-1:0] = map_rd_data;
                map_req.rd_en          = 1'b1;
                map_req.rd_row         = row_of(last_reg);
                state_next             = ST_LOAD;
            end

            ST_LOAD:
            begin
                win_next[2*ROW_BITS-1:ROW_BITS] = map_rd_data;
                state_next                      = ST_WALK;
            end

            ST_WALK:
            begin
                if (kind_reg == KIND_WRITE)
                begin
                    // Whole range gets marked; keep the pre-request bits of the ends.
                    win_next[pos_reg] = 1'b1;
                    if (blk_reg == first_reg)
                    begin
                        f_orig_next = cur;
                    end
                    if (blk_reg == last_reg)
                    begin
                        l_orig_next = cur;
                    end
                end
                else if (!cur)
                begin
                    if (adj)
                    begin
                        open_len_next     = open_len_reg + 6'd1;
                        win_next[pos_reg] = 1'b1;
                    end
                    else
                    begin
                        if (open_len_reg != '0)
                        begin
                            // Gap closes the open run; it is final once the cap is hit.
                            res_valid_next  = 1'b1;
                            res_fv_next     = 1'b1;
                            res_first_next  = open_first_reg;
                            res_blocks_next = open_len_reg;
                            cnt_v           = count_reg + 5'd1;
                            res_last_next   = (cnt_v == 5'(RUN_CAP));
                        end
                        count_next = cnt_v;
                        if (cnt_v < 5'(RUN_CAP))
                        begin
                            open_first_next   = blk_reg;
                            open_len_next     = 6'd1;
                            win_next[pos_reg] = 1'b1;
                        end
                        else
                        begin
                            open_len_next = '0;
                        end
                    end
                end
                blk_next = blk_reg + 16'd1;
                pos_next = pos_reg + 6'd1;
                if (blk_reg == last_reg)
                begin
                    state_next = ST_WB0;
                end
            end

            ST_WB0:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_row  = row_of(first_reg);
                map_req.wr_data = win_reg[ROW_BITS-1:0];
                state_next      = two_rows ? ST_WB1 : ST_FIN;
            end

            ST_WB1:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_row  = row_of(last_reg);
                map_req.wr_data = win_reg[2*ROW_BITS-1:ROW_BITS];
                state_next      = ST_FIN;
            end

            ST_FIN:
            begin
                if (kind_reg != KIND_WRITE)
                begin
                    if (open_len_reg != '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_fv_next     = 1'b1;
                        res_first_next  = open_first_reg;
                        res_blocks_next = open_len_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        res_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (mod_stat.done)
                begin
                    res_valid_next = 1'b1;
                    if (get_first)
                    begin
                        res_fv_next     = 1'b1;
                        res_first_next  = first_reg;
                        res_blocks_next = 6'd1;
                        res_last_next   = !get_last;
                        state_next      = get_last ? ST_WLAST : ST_IDLE;
                    end
                    else if (get_last)
                    begin
                        res_fv_next     = 1'b1;
                        res_first_next  = last_reg;
                        res_blocks_next = 6'd1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_WLAST:
            begin
                res_valid_next  = 1'b1;
                res_fv_next     = 1'b1;
                res_first_next  = last_reg;
                res_blocks_next = 6'd1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            count_reg     <= '0;
            open_len_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            count_reg     <= count_next;
            open_len_reg  <= open_len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        open_first_reg <= open_first_next;
        kind_reg       <= kind_next;
        blk_reg        <= blk_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        pos_reg        <= pos_next;
        win_reg        <= win_next;
        f_orig_reg     <= f_orig_next;
        l_orig_reg     <= l_orig_next;
        res_fv_reg     <= res_fv_next;
        res_first_reg  <= res_first_next;
        res_blocks_reg <= res_blocks_next;
        res_err_reg    <= res_err_next;
        res_last_reg   <= res_last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign fetch_valid  = res_fv_reg;
    assign run_first    = res_first_reg;
    assign run_blocks   = res_blocks_reg;
    assign range_error  = res_err_reg;
    assign last         = res_last_reg;

    // A fetch run always carries between one and MAX_SPAN blocks.
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && fetch_valid) |-> ((run_blocks != 6'd0) && (run_blocks <= 6'(MAX_SPAN))))
        else $error("fetch run length out of range");

    // A rejected request answers with one final result and no fetch.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_error) |-> (last && !fetch_valid))
        else $error("range error result malformed");

    // Kind "other" answers in the next cycle with a single no-fetch result.
    a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_OTHER)) |=> (result_valid && last && !fetch_valid && !busy))
        else $error("no-change request not answered");

    // Planned runs never exceed the cap, and an open run never exceeds the window.
    a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 5'(RUN_CAP)) && (open_len_reg <= 6'(MAX_SPAN)))
        else $error("run bookkeeping overflow");

    // The map is only written during the clearing pass or write-back.
    a_map_wr: assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en |-> ((state_reg == ST_CLEAR) || (state_reg == ST_WB0)
                           || (state_reg == ST_WB1)))
        else $error("bitmap written outside clear or write-back");

endmodule

`default_nettype wire

// ===== design/cfrp_map.sv =====
// Cached-block bitmap: row memory, one read and one write port, registered read.
`default_nettype none

module cfrp_map (
    input  wire logic                          clk,
    input  wire cfrp_pkg::map_req_t            req,
    output logic [cfrp_pkg::ROW_BITS-1:0]      rd_data
);
    import cfrp_pkg::*;

    logic [ROW_BITS-1:0] mem [MAP_ROWS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_row] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_row];
        end
    end

endmodule

`default_nettype wire

// ===== design/cfrp_mod.sv =====
// Remainder by BLOCK_BYTES for two operands side by side, registered on start.
`default_nettype none

module cfrp_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [cfrp_pkg::MOD_W-1:0]  op0,
    input  wire logic [cfrp_pkg::MOD_W-1:0]  op1,
    output cfrp_pkg::mod_stat_t              stat
);
    import cfrp_pkg::*;

    // BLOCK_BYTES is a power of two, so the remainder is just the low bits.
    localparam logic [MOD_W-1:0] BLOCK_DIV = MOD_W'(BLOCK_BYTES);

    logic             done_reg, done_next;
    logic [MOD_W-1:0] r0_reg,   r0_next;
    logic [MOD_W-1:0] r1_reg,   r1_next;

    always_comb
    begin
        done_next = done_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        if (start)
        begin
            done_next = 1'b1;
            r0_next   = op0 % BLOCK_DIV;
            r1_next   = op1 % BLOCK_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

    assign stat.done    = done_reg;
    assign stat.rem0_nz = (r0_reg != '0);
    assign stat.rem1_nz = (r1_reg != '0);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the cache fill run planner: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import cfrp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [15:0] first_block;
    logic [15:0] last_block;
    logic [27:0] byte_offset;
    logic [17:0] byte_length;
    logic        result_valid;
    logic        fetch_valid;
    logic [15:0] run_first;
    logic [5:0]  run_blocks;
    logic        range_error;
    logic        last;

    // 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    cache_fill_run_planner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .first_block  (first_block),
        .last_block   (last_block),
        .byte_offset  (byte_offset),
        .byte_length  (byte_length),
        .result_valid (result_valid),
        .fetch_valid  (fetch_valid),
        .run_first    (run_first),
        .run_blocks   (run_blocks),
        .range_error  (range_error),
        .last         (last)
    );

    // ------------------------------------------------------------------
    // Expected-result store and the testbench's own copy of the block map
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        fetch_valid;
        logic [15:0] run_first;
        logic [5:0]  run_blocks;
        logic        range_error;
        logic        last;
    } run_result_t;

    run_result_t planned_results[$];
    bit          block_cached [0:NUM_BLOCKS-1];   // all clear, as after reset
    int          mismatches;
    int          items_sent;
    int          quiet_left;                      // items left in a no-idle stretch
    run_result_t want;

    logic [1:0] good_kinds [0:2] = '{KIND_READ, KIND_CACHE, KIND_WRITE};

    function automatic void add_result(input logic fv, input logic [15:0] lo,
                                       input logic [5:0] blocks, input logic err,
                                       input logic fin);
        run_result_t r;
        r.fetch_valid = fv;
        r.run_first   = lo;
        r.run_blocks  = blocks;
        r.range_error = err;
        r.last        = fin;
        planned_results.push_back(r);
    endfunction

    // Works out the fetch runs one accepted request should produce and
    // updates the map copy the same way the block does.
    function automatic void plan_request(input logic [1:0] k, input logic [15:0] f,
                                         input logic [15:0] l, input logic [27:0] off,
                                         input logic [17:0] len);
        logic [15:0] run_lo [0:OUT_LIMIT-1];
        int          run_len [0:OUT_LIMIT-1];
        int          n_runs;
        int          open_lo;
        int          open_len;
        int          fi;
        int          li;
        logic        head_miss;
        logic        tail_miss;
        logic [28:0] tail_addr;

        n_runs   = 0;
        open_lo  = 0;
        open_len = 0;
        fi       = f;
        li       = l;

        if (k == KIND_OTHER)
        begin
            add_result(1'b0, '0, '0, 1'b0, 1'b1);
            return;
        end
        // reversed range, span over the limit, or end past the map
        if (li < fi || li - fi + 1 > MAX_SPAN || li >= NUM_BLOCKS)
        begin
            add_result(1'b0, '0, '0, 1'b1, 1'b1);
            return;
        end

        if (k == KIND_WRITE)
        begin
            // misses are judged against the map before the write marks it
            tail_addr = {1'b0, off} + len;
            head_miss = (off % BLOCK_BYTES != 0) && !block_cached[fi];
            tail_miss = (tail_addr % BLOCK_BYTES != 0) && (li > fi || !head_miss) &&
                        !block_cached[li];
            for (int b = fi; b <= li; b++)
                block_cached[b] = 1'b1;
            if (head_miss)
            begin
                run_lo[n_runs]  = f;
                run_len[n_runs] = 1;
                n_runs++;
            end
            if (tail_miss)
            begin
                run_lo[n_runs]  = l;
                run_len[n_runs] = 1;
                n_runs++;
            end
        end
        else
        begin
            for (int b = fi; b <= li; b++)
            begin
                if (!block_cached[b])
                begin
                    if (open_len != 0 && b == open_lo + open_len)
                    begin
                        open_len++;
                        block_cached[b] = 1'b1;
                    end
                    else
                    begin
                        if (open_len != 0)
                        begin
                            run_lo[n_runs]  = open_lo[15:0];
                            run_len[n_runs] = open_len;
                            n_runs++;
                            open_len = 0;
                        end
                        // at the run cap a new miss is skipped and stays uncached
                        if (n_runs < RUN_CAP)
                        begin
                            open_lo         = b;
                            open_len        = 1;
                            block_cached[b] = 1'b1;
                        end
                    end
                end
            end
            if (open_len != 0 && n_runs < RUN_CAP)
            begin
                run_lo[n_runs]  = open_lo[15:0];
                run_len[n_runs] = open_len;
                n_runs++;
            end
        end

        if (n_runs == 0)
            add_result(1'b0, '0, '0, 1'b0, 1'b1);
        else
            for (int i = 0; i < n_runs; i++)
                add_result(1'b1, run_lo[i], run_len[i][5:0], 1'b0, i == n_runs - 1);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Idle before the item: mostly none or short, now and then long, and
    // whole stretches with none at all.
    task automatic idle_before_item();
        int gap;
        int roll;
        gap = 0;
        if (quiet_left > 0)
            quiet_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                quiet_left = $urandom_range(10, 30);
            else if (roll < 50)
                gap = 0;
            else if (roll < 88)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drives one item and holds it until the block takes it.
    task automatic send_item(input logic [1:0] k, input logic [15:0] f, input logic [15:0] l,
                             input logic [27:0] off, input logic [17:0] len);
        idle_before_item();
        @(negedge clk);
        start       <= 1'b1;
        kind        <= k;
        first_block <= f;
        last_block  <= l;
        byte_offset <= off;
        byte_length <= len;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        plan_request(k, f, l, off, len);
        items_sent++;
    endtask

    // Byte range near block blk: aligned, partial, or anything at all.
    task automatic pick_bytes(input logic [15:0] blk, output logic [27:0] off,
                              output logic [17:0] len);
        case ($urandom_range(0, 2))
            0: off = {blk, 12'h000};
            1: off = {blk, 12'h000} + 28'($urandom_range(1, BLOCK_BYTES - 1));
            default: off = 28'($urandom);
        endcase
        if ($urandom_range(0, 1) == 0)
            len = 18'(BLOCK_BYTES * $urandom_range(1, MAX_SPAN));
        else
            len = 18'($urandom_range(1, 131072));
    endtask

    task automatic send_range(input logic [1:0] k, input int f, input int span);
        logic [27:0] off;
        logic [17:0] len;
        pick_bytes(f[15:0], off, len);
        send_item(k, f[15:0], 16'(f + span - 1), off, len);
    endtask

    // Mostly a crowded low region so hits and misses mix; sometimes anywhere.
    function automatic int pick_base(input int span);
        int base;
        if ($urandom_range(0, 99) < 70)
            base = $urandom_range(0, 8191);
        else
            base = $urandom_range(0, NUM_BLOCKS - 1);
        if (base > NUM_BLOCKS - span)
            base = NUM_BLOCKS - span;
        return base;
    endfunction

    function automatic int pick_span();
        if ($urandom_range(0, 99) < 60)
            return $urandom_range(1, 8);
        else if ($urandom_range(0, 3) == 0)
            return MAX_SPAN;
        else
            return $urandom_range(9, MAX_SPAN);
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_fresh_reads();
        send_item(KIND_READ, 16'd0, 16'd31, 28'd0, 18'd1);            // one run of 32
        send_item(KIND_READ, 16'd0, 16'd31, 28'd0, 18'd1);            // all hit now
        send_item(KIND_CACHE, 16'd65504, 16'd65535, 28'hFFFFFFF, 18'd131072);
        send_item(KIND_READ, 16'd65535, 16'd65535, 28'd0, 18'd4096);  // top block, cached
    endtask

    task automatic test_range_errors();
        send_item(KIND_READ, 16'd10, 16'd9, 28'd0, 18'd1);            // reversed
        send_item(KIND_CACHE, 16'd0, 16'd32, 28'd0, 18'd1);           // span one too long
        send_item(KIND_WRITE, 16'd0, 16'd65535, 28'd5, 18'd7);
        send_item(KIND_WRITE, 16'd65535, 16'd0, 28'hFFFFFFF, 18'd131072);
    endtask

    task automatic test_other_kind();
        send_item(KIND_OTHER, 16'hFFFF, 16'd0, 28'hFFFFFFF, 18'd131072);
        send_item(KIND_OTHER, 16'd0, 16'd0, 28'd0, 18'd1);
    endtask

    task automatic test_write_edges();
        // aligned both ends: marks, fetches nothing
        send_item(KIND_WRITE, 16'd200, 16'd203, {16'd200, 12'h000}, 18'd16384);
        // partial head and tail, both uncached
        send_item(KIND_WRITE, 16'd210, 16'd213, {16'd210, 12'h005}, 18'd16384);
        // single block, partial head and tail: one fetch
        send_item(KIND_WRITE, 16'd220, 16'd220, {16'd220, 12'h001}, 18'd10);
        // single block, aligned head, partial tail
        send_item(KIND_WRITE, 16'd230, 16'd230, {16'd230, 12'h000}, 18'd100);
        // same partial write again: everything already cached
        send_item(KIND_WRITE, 16'd210, 16'd213, {16'd210, 12'h005}, 18'd16384);
        // largest offset: head partial, tail lands on a boundary
        send_item(KIND_WRITE, 16'd250, 16'd250, 28'hFFFFFFF, 18'd1);
    endtask

    task automatic test_fragmented_runs();
        // every other block cached, then one read splits into many runs
        for (int i = 301; i <= 315; i += 2)
            send_range(good_kinds[i % 2], i, 1);
        send_range(KIND_READ, 300, MAX_SPAN);
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int target;
        int roll;
        int base;
        int span;
        int lo;
        int hi;
        target = items_sent + 175;
        while (items_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                // comb: scatter cached blocks, then read across them
                base = pick_base(MAX_SPAN);
                if ($urandom_range(0, 1) == 0)
                    for (int i = 1; i < MAX_SPAN; i += 2)
                        send_range(good_kinds[$urandom_range(0, 2)], base + i, 1);
                else
                    for (int i = 0; i < MAX_SPAN; i++)
                        if ($urandom_range(0, 3) == 0)
                            send_range(good_kinds[$urandom_range(0, 2)], base + i, 1);
                send_range(good_kinds[$urandom_range(0, 1)], base, MAX_SPAN);
            end
            else if (roll < 62)
            begin
                span = pick_span();
                send_range(good_kinds[$urandom_range(0, 2)], pick_base(span), span);
            end
            else if (roll < 77)
            begin
                // write, then read an overlapping window
                span = pick_span();
                base = pick_base(span);
                send_range(KIND_WRITE, base, span);
                lo = (base >= 2) ? base - 2 : 0;
                hi = base + span + 1;
                if (hi > NUM_BLOCKS - 1)
                    hi = NUM_BLOCKS - 1;
                if (hi - lo + 1 > MAX_SPAN)
                    hi = lo + MAX_SPAN - 1;
                send_range(good_kinds[$urandom_range(0, 1)], lo, hi - lo + 1);
            end
            else if (roll < 90)
            begin
                // broken ranges
                lo = $urandom_range(1, NUM_BLOCKS - 1);
                if ($urandom_range(0, 1) == 0)
                    send_item(good_kinds[$urandom_range(0, 2)], lo[15:0],
                              16'($urandom_range(0, lo - 1)), 28'($urandom),
                              18'($urandom_range(1, 131072)));
                else
                begin
                    lo = $urandom_range(0, NUM_BLOCKS - 1 - MAX_SPAN);
                    hi = $urandom_range(lo + MAX_SPAN, NUM_BLOCKS - 1);
                    send_item(good_kinds[$urandom_range(0, 2)], lo[15:0], hi[15:0],
                              28'($urandom), 18'($urandom_range(1, 131072)));
                end
            end
            else
                send_item(KIND_OTHER, 16'($urandom), 16'($urandom), 28'($urandom),
                          18'($urandom_range(1, 131072)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so every strobe is taken
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                          input logic [15:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_val,
                     got_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (planned_results.size() == 0)
            begin
                $display("%0t: result with none pending, expected nothing, %s",
                         $realtime, "got");
                $display("    fv=%0b first=%0d blocks=%0d err=%0b last=%0b",
                         fetch_valid, run_first, run_blocks, range_error, last);
                mismatches++;
            end
            else
            begin
                want = planned_results.pop_front();
                compare_field("fetch_valid", want.fetch_valid, fetch_valid);
                compare_field("run_first", want.run_first, run_first);
                compare_field("run_blocks", want.run_blocks, run_blocks);
                compare_field("range_error", want.range_error, range_error);
                compare_field("last", want.last, last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatches  = 0;
        items_sent  = 0;
        quiet_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_READ;
        first_block = '0;
        last_block  = '0;
        byte_offset = '0;
        byte_length = 18'd1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // the map clear after reset keeps busy high; send_item waits it out
        test_fresh_reads();
        test_range_errors();
        test_other_kind();
        test_write_edges();
        test_fragmented_runs();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        while (planned_results.size() != 0)
            @(posedge clk);
        // wait past the longest request to catch any stray strobes
        repeat (64) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: 1 ms covers the slowest run, with the map clear and every item at its
    // longest busy time and idle gap.
    initial
    begin
        #1_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
